>>> hw/rtl/tstes_pkg.sv
// Shared types, constants and calendar tables for the timestamp-to-seconds block.
package tstes_pkg;

  localparam int unsigned YEAR_W = 14;
  localparam int unsigned FLD_W  = 7;
  localparam int unsigned SECS_W = 38;

  localparam logic [YEAR_W-1:0] EARLIEST_RESET = 14'd1999;
  localparam logic [8:0]        DAYS_PER_YEAR  = 9'd365;
  localparam logic [SECS_W-1:0] DAYS_TO_1970   = 38'd719528;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } in_word_t;

  typedef struct packed {
    logic              valid_res;
    logic [SECS_W-1:0] epoch_seconds;
  } out_word_t;

  // One parsed text handed from the intake to the converter.
  typedef struct packed {
    logic [YEAR_W-1:0] year;
    logic [FLD_W-1:0]  month;
    logic [FLD_W-1:0]  day;
    logic [FLD_W-1:0]  hour;
    logic [FLD_W-1:0]  minute;
    logic [FLD_W-1:0]  second;
    logic              form_ok;
  } job_t;

  // Status of the divide-by-100 unit.
  typedef struct packed {
    logic       busy;
    logic [7:0] quot;
    logic [6:0] rem;
  } div_stat_t;

  // Days before the first of month m (1..12) in a common year.
  function automatic logic [8:0] month_start(input logic [FLD_W-1:0] m);
    logic [8:0] r;
    unique case (m)
      7'd1:    r = 9'd0;
      7'd2:    r = 9'd31;
      7'd3:    r = 9'd59;
      7'd4:    r = 9'd90;
      7'd5:    r = 9'd120;
      7'd6:    r = 9'd151;
      7'd7:    r = 9'd181;
      7'd8:    r = 9'd212;
      7'd9:    r = 9'd243;
      7'd10:   r = 9'd273;
      7'd11:   r = 9'd304;
      7'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // Length of month m (1..12) in a common year.
  function automatic logic [4:0] month_len(input logic [FLD_W-1:0] m);
    logic [4:0] r;
    unique case (m)
      7'd2:                      r = 5'd28;
      7'd4, 7'd6, 7'd9, 7'd11:   r = 5'd30;
      7'd1, 7'd3, 7'd5, 7'd7,
      7'd8, 7'd10, 7'd12:        r = 5'd31;
      default:                   r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

>>> hw/rtl/tstes_intake.sv
// Character intake: checks the text shape and gathers the date and time digits.
module tstes_intake (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  tstes_pkg::in_word_t in_data,
  output logic              job_valid,
  output tstes_pkg::job_t   job,
  input  logic              job_take
);
  import tstes_pkg::*;

  localparam logic [1:0] SFX_NONE = 2'd0;
  localparam logic [1:0] SFX_Z    = 2'd1;
  localparam logic [1:0] SFX_DOT  = 2'd2;

  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_Z     = 8'h5A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [4:0] P_DASH1  = 5'd4;
  localparam logic [4:0] P_DASH2  = 5'd7;
  localparam logic [4:0] P_TEE    = 5'd10;
  localparam logic [4:0] P_COL1   = 5'd13;
  localparam logic [4:0] P_COL2   = 5'd16;
  localparam logic [4:0] P_SFX    = 5'd19;
  localparam logic [4:0] P_MS_LO  = 5'd20;
  localparam logic [4:0] P_MS_HI  = 5'd22;
  localparam logic [4:0] P_MS_Z   = 5'd23;
  localparam logic [4:0] P_YR_END = 5'd3;
  localparam logic [4:0] P_MO_END = 5'd6;
  localparam logic [4:0] P_DY_END = 5'd9;
  localparam logic [4:0] P_HR_END = 5'd12;
  localparam logic [4:0] P_MI_END = 5'd15;
  localparam logic [4:0] POS_MAX  = 5'd24;
  localparam logic [4:0] LEN_BASE = 5'd19;
  localparam logic [4:0] LEN_Z    = 5'd20;
  localparam logic [4:0] LEN_MS   = 5'd23;

  logic [4:0]        pos_r, pos_nxt;
  logic [YEAR_W-1:0] year_r, year_nxt;
  logic [FLD_W-1:0]  mon_r, mon_nxt, day_r, day_nxt, hr_r, hr_nxt;
  logic [FLD_W-1:0]  min_r, min_nxt, sec_r, sec_nxt;
  logic              err_r, err_nxt;
  logic [1:0]        sfx_r, sfx_nxt;
  logic              jv_r, jv_nxt;
  job_t              job_r, job_nxt;

  logic              accept;
  logic              digit;
  logic [3:0]        dval;
  logic [7:0]        c;

  assign in_stall  = jv_r;
  assign accept    = in_valid && !jv_r;
  assign c         = in_data.character;
  assign digit     = (c >= CH_ZERO) && (c <= CH_NINE);
  assign dval      = c[3:0];
  assign job_valid = jv_r;
  assign job       = job_r;

  // acc*10 + digit, kept to the field width
  function automatic logic [YEAR_W-1:0] dec_acc(input logic [YEAR_W-1:0] a,
                                               input logic [3:0] d);
    return (a << 3) + (a << 1) + YEAR_W'(d);
  endfunction

  always_comb begin
    pos_nxt  = pos_r;
    year_nxt = year_r;
    mon_nxt  = mon_r;
    day_nxt  = day_r;
    hr_nxt   = hr_r;
    min_nxt  = min_r;
    sec_nxt  = sec_r;
    err_nxt  = err_r;
    sfx_nxt  = sfx_r;
    jv_nxt   = jv_r;
    job_nxt  = job_r;
    if (job_take) begin
      jv_nxt = 1'b0;
    end
    if (accept) begin
      if (pos_r >= POS_MAX) begin
        err_nxt = 1'b1;
      end else begin
        pos_nxt = pos_r + 5'd1;
        priority if (pos_r == P_DASH1 || pos_r == P_DASH2) begin
          if (c != CH_DASH) err_nxt = 1'b1;
        end else if (pos_r == P_TEE) begin
          if (c != CH_T) err_nxt = 1'b1;
        end else if (pos_r == P_COL1 || pos_r == P_COL2) begin
          if (c != CH_COLON) err_nxt = 1'b1;
        end else if (pos_r == P_SFX) begin
          priority if (c == CH_Z) sfx_nxt = SFX_Z;
          else if (c == CH_DOT) sfx_nxt = SFX_DOT;
          else err_nxt = 1'b1;
        end else if (pos_r >= P_MS_LO && pos_r <= P_MS_HI) begin
          if (sfx_r != SFX_DOT || !digit) err_nxt = 1'b1;
        end else if (pos_r == P_MS_Z) begin
          if (sfx_r != SFX_DOT || c != CH_Z) err_nxt = 1'b1;
        end else if (!digit) begin
          err_nxt = 1'b1;
        end else if (pos_r <= P_YR_END) begin
          year_nxt = dec_acc(year_r, dval);
        end else if (pos_r <= P_MO_END) begin
          mon_nxt = FLD_W'(dec_acc(YEAR_W'(mon_r), dval));
        end else if (pos_r <= P_DY_END) begin
          day_nxt = FLD_W'(dec_acc(YEAR_W'(day_r), dval));
        end else if (pos_r <= P_HR_END) begin
          hr_nxt = FLD_W'(dec_acc(YEAR_W'(hr_r), dval));
        end else if (pos_r <= P_MI_END) begin
          min_nxt = FLD_W'(dec_acc(YEAR_W'(min_r), dval));
        end else begin
          sec_nxt = FLD_W'(dec_acc(YEAR_W'(sec_r), dval));
        end
      end
      if (in_data.last) begin
        job_nxt.year    = year_nxt;
        job_nxt.month   = mon_nxt;
        job_nxt.day     = day_nxt;
        job_nxt.hour    = hr_nxt;
        job_nxt.minute  = min_nxt;
        job_nxt.second  = sec_nxt;
        job_nxt.form_ok = !err_nxt &&
                          (pos_nxt == LEN_BASE || (pos_nxt == LEN_Z && sfx_nxt == SFX_Z) ||
                           pos_nxt == LEN_MS || pos_nxt == POS_MAX);
        jv_nxt   = 1'b1;
        pos_nxt  = '0;
        year_nxt = '0;
        mon_nxt  = '0;
        day_nxt  = '0;
        hr_nxt   = '0;
        min_nxt  = '0;
        sec_nxt  = '0;
        err_nxt  = 1'b0;
        sfx_nxt  = SFX_NONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      year_r <= '0;
      mon_r  <= '0;
      day_r  <= '0;
      hr_r   <= '0;
      min_r  <= '0;
      sec_r  <= '0;
      err_r  <= 1'b0;
      sfx_r  <= SFX_NONE;
      jv_r   <= 1'b0;
    end else begin
      pos_r  <= pos_nxt;
      year_r <= year_nxt;
      mon_r  <= mon_nxt;
      day_r  <= day_nxt;
      hr_r   <= hr_nxt;
      min_r  <= min_nxt;
      sec_r  <= sec_nxt;
      err_r  <= err_nxt;
      sfx_r  <= sfx_nxt;
      jv_r   <= jv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
  end

endmodule

>>> hw/rtl/tstes_div100.sv
// Bit-serial restoring divider of the year by 100, one quotient bit per cycle.
module tstes_div100 (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [tstes_pkg::YEAR_W-1:0]   dividend,
  output tstes_pkg::div_stat_t           stat
);
  import tstes_pkg::*;

  localparam logic [3:0] LAST_STEP = 4'(YEAR_W - 1);
  localparam logic [7:0] DIVISOR   = 8'd100;

  logic [YEAR_W-1:0] sh_r, sh_nxt;
  logic [6:0]        rem_r, rem_nxt;
  logic [3:0]        cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic [7:0]        trial;
  logic              ge;

  assign trial = {rem_r, sh_r[YEAR_W-1]};
  assign ge    = trial >= DIVISOR;

  always_comb begin
    sh_nxt   = sh_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      sh_nxt   = dividend;
      rem_nxt  = '0;
      cnt_nxt  = LAST_STEP;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // dividend bits leave at the top, quotient bits enter at the bottom
      sh_nxt  = {sh_r[YEAR_W-2:0], ge};
      rem_nxt = ge ? 7'(trial - DIVISOR) : trial[6:0];
      cnt_nxt = cnt_r - 4'd1;
      if (cnt_r == '0) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_r  <= sh_nxt;
    rem_r <= rem_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.quot = sh_r[7:0];
  assign stat.rem  = rem_r;

endmodule

>>> hw/rtl/tstes_conv.sv
// Date check and seconds conversion sequencer: calendar terms, then Horner steps.
module tstes_conv (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             job_valid,
  input  tstes_pkg::job_t                  job,
  output logic                             job_take,
  input  logic [tstes_pkg::YEAR_W-1:0]     earliest,
  output logic                             res_valid,
  output tstes_pkg::out_word_t             res,
  input  logic                             res_take
);
  import tstes_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DIV  = 4'd1;
  localparam logic [3:0] S_YEAR = 4'd2;
  localparam logic [3:0] S_CENT = 4'd3;
  localparam logic [3:0] S_DATE = 4'd4;
  localparam logic [3:0] S_HOUR = 4'd5;
  localparam logic [3:0] S_MIN  = 4'd6;
  localparam logic [3:0] S_SEC  = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;

  localparam logic [FLD_W-1:0] MAX_HOUR = 7'd23;
  localparam logic [FLD_W-1:0] MAX_MS   = 7'd59;
  localparam logic [FLD_W-1:0] FEB      = 7'd2;
  localparam logic [FLD_W-1:0] DEC      = 7'd12;

  logic [3:0]        st_r, st_nxt;
  job_t              jb_r, jb_nxt;
  logic [SECS_W-1:0] acc_r, acc_nxt;
  logic              leap_r, leap_nxt;
  logic              ok_r, ok_nxt;

  div_stat_t         dstat;
  logic              r_nz, q4_nz, leap;
  logic [SECS_W-1:0] c4, c100, c400;
  logic [22:0]       yprod;
  logic [4:0]        dim;
  logic [SECS_W-1:0] horner;
  logic [FLD_W-1:0]  hdig;

  assign job_take = (st_r == S_IDLE) && job_valid;

  tstes_div100 u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (job_take),
    .dividend (job.year),
    .stat     (dstat)
  );

  // ceilings of y/4 from the year bits, and of y/100, y/400 from the quotient and remainder by 100
  assign r_nz  = dstat.rem != '0;
  assign q4_nz = dstat.quot[1:0] != 2'd0;
  assign leap  = (jb_r.year[1:0] == 2'd0 && r_nz) || (!r_nz && !q4_nz);
  assign c4    = SECS_W'(jb_r.year[YEAR_W-1:2]) + SECS_W'(jb_r.year[1:0] != 2'd0);
  assign c100  = SECS_W'(dstat.quot) + SECS_W'(r_nz);
  assign c400  = SECS_W'(dstat.quot[7:2]) + SECS_W'(q4_nz || r_nz);
  assign yprod = 23'(jb_r.year) * 23'(DAYS_PER_YEAR);
  assign dim   = month_len(jb_r.month) + 5'(jb_r.month == FEB && leap_r);

  // acc*24 + hour, or acc*60 + minute/second
  assign hdig   = (st_r == S_HOUR) ? jb_r.hour : ((st_r == S_MIN) ? jb_r.minute : jb_r.second);
  assign horner = ((st_r == S_HOUR) ? ((acc_r << 4) + (acc_r << 3))
                                    : ((acc_r << 6) - (acc_r << 2))) + SECS_W'(hdig);

  always_comb begin
    st_nxt   = st_r;
    jb_nxt   = jb_r;
    acc_nxt  = acc_r;
    leap_nxt = leap_r;
    ok_nxt   = ok_r;
    unique case (st_r)
      S_IDLE: begin
        if (job_valid) begin
          jb_nxt = job;
          st_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (!dstat.busy) st_nxt = S_YEAR;
      end
      S_YEAR: begin
        acc_nxt = SECS_W'(yprod);
        st_nxt  = S_CENT;
      end
      S_CENT: begin
        acc_nxt  = acc_r + c4 - c100 + c400 - DAYS_TO_1970;
        leap_nxt = leap;
        st_nxt   = S_DATE;
      end
      S_DATE: begin
        acc_nxt = acc_r + SECS_W'(month_start(jb_r.month))
                + SECS_W'(jb_r.month > FEB && leap_r) + SECS_W'(jb_r.day) - SECS_W'(1);
        ok_nxt  = jb_r.form_ok && jb_r.month != '0 && jb_r.month <= DEC &&
                  jb_r.day != '0 && jb_r.day <= FLD_W'(dim) && jb_r.year >= earliest &&
                  jb_r.hour <= MAX_HOUR && jb_r.minute <= MAX_MS && jb_r.second <= MAX_MS;
        st_nxt  = S_HOUR;
      end
      S_HOUR: begin
        acc_nxt = horner;
        st_nxt  = S_MIN;
      end
      S_MIN: begin
        acc_nxt = horner;
        st_nxt  = S_SEC;
      end
      S_SEC: begin
        acc_nxt = horner;
        st_nxt  = S_DONE;
      end
      S_DONE: begin
        if (res_take) st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    jb_r   <= jb_nxt;
    acc_r  <= acc_nxt;
    leap_r <= leap_nxt;
    ok_r   <= ok_nxt;
  end

  assign res_valid         = st_r == S_DONE;
  assign res.valid_res     = ok_r;
  assign res.epoch_seconds = ok_r ? acc_r : '0;

endmodule

>>> hw/rtl/timestamp_text_to_epoch_seconds_core.sv
// Top level: timestamp text to seconds since 1970, intake, converter and output word register.
//
// Takes a timestamp text one character per input word, the final character marked
// by last, and gives one output word per text: valid_res and epoch_seconds. Accepted
// shapes are YYYY-MM-DDTHH:MM:SS with nothing, Z, .ddd or .dddZ after it; the date is
// checked against the Gregorian calendar, the year against cfg earliest_year (reset
// 1999), and hour, minute and second against their limits. Milliseconds are dropped;
// epoch_seconds is zero for an invalid text and wraps to 38 bits for years before 1970.
// Characters are taken at one per cycle while in_stall is low. When the final character
// lands, the text is parked in a job register and the input stalls until the converter
// takes the job: it starts a bit-serial divide of the year by 100, waits for the divide
// to finish, then works out in turn the year term, the century terms, the month and
// day terms and the hour, minute and second Horner steps. The word then moves into the
// output register once that register is free. Characters of the next text keep flowing
// meanwhile; once its final character is parked, the input stalls until the converter
// is free again.
// earliest_year may only be written while no text is in flight.
module timestamp_text_to_epoch_seconds_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  tstes_pkg::in_word_t             in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output tstes_pkg::out_word_t            out_data,
  input  logic                            cfg_we,
  input  logic [tstes_pkg::YEAR_W-1:0]    cfg_wdata
);
  import tstes_pkg::*;

  logic [YEAR_W-1:0] earliest_r;   // minimum accepted year
  logic              ov_r, ov_nxt; // output word register full
  out_word_t         od_r;

  logic              job_valid, job_take;
  job_t              job;
  logic              res_valid, res_take;
  out_word_t         res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      earliest_r <= EARLIEST_RESET;
    end else if (cfg_we) begin
      earliest_r <= cfg_wdata;
    end
  end

  tstes_intake u_intake (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .job_valid (job_valid),
    .job       (job),
    .job_take  (job_take)
  );

  tstes_conv u_conv (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_valid),
    .job       (job),
    .job_take  (job_take),
    .earliest  (earliest_r),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take)
  );

  // Output word register: loads when empty or being drained this cycle.
  assign res_take = res_valid && (!ov_r || !out_stall);

  always_comb begin
    ov_nxt = ov_r;
    if (res_take) begin
      ov_nxt = 1'b1;
    end else if (!out_stall) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      od_r <= res;
    end
  end

  assign out_valid = ov_r;
  assign out_data  = od_r;

`ifndef ASSERT_OFF
  // A final character parks its text, so the next edge must hold the channel stalled.
  a_last_parks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_data.last) |=> in_stall)
    else $error("final character accepted without parking the text");

  // An invalid text never carries a seconds count.
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.valid_res || out_data.epoch_seconds == '0))
    else $error("invalid result word with non-zero seconds");

  // A result moves into the output register only when it has room.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && out_stall) |-> !res_take)
    else $error("output word overwritten while stalled");
`endif

endmodule

>>> verif/tb_timestamp_text_to_epoch_seconds_core.sv
// Testbench for the timestamp text to epoch seconds core: directed table, then random texts.
module tb_timestamp_text_to_epoch_seconds_core;
  import tstes_pkg::*;

  // Run shape: one random phase per idling mode and earliest-year setting.
  localparam int PHASES        = 6;
  localparam int PHASE_ITEMS   = 110;     // characters sent per random phase, at least
  localparam int SETTLE_CYCLES = 40;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int RUN_LIMIT     = 2000000; // time units, far beyond the slowest run
  localparam int DIR_ROWS      = 22;
  localparam int MAX_LEN       = 24;      // position saturates here

  // Characters the parser cares about.
  localparam logic [7:0] CH_ZERO  = "0";
  localparam logic [7:0] CH_NINE  = "9";
  localparam logic [7:0] CH_DASH  = "-";
  localparam logic [7:0] CH_T     = "T";
  localparam logic [7:0] CH_COLON = ":";
  localparam logic [7:0] CH_Z     = "Z";
  localparam logic [7:0] CH_DOT   = ".";

  typedef enum logic [1:0] {SFX_NONE, SFX_Z, SFX_DOT} sfx_kind_t;
  typedef enum logic [1:0] {IDLE_NONE, IDLE_TX, IDLE_RX, IDLE_BOTH} idle_mode_t;
  // How a directed row is checked: by the parser model, or by a typed-in word.
  typedef enum logic [1:0] {CHK_MODEL, CHK_REJECT, CHK_ACCEPT} row_chk_t;

  typedef struct packed {
    logic      fixed;
    out_word_t word;
  } typed_word_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_word_t             in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_word_t            out_data;
  logic                 cfg_we = 1'b0;
  logic [YEAR_W-1:0]    cfg_wdata = '0;

  timestamp_text_to_epoch_seconds_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop in case the block hangs.
  initial begin
    #(RUN_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Parser model state: our own copy of the text being assembled.
  // ---------------------------------------------------------------------------
  logic [YEAR_W-1:0] earliest_q = EARLIEST_RESET;
  logic [4:0]        pos_q  = '0;
  logic [YEAR_W-1:0] year_q = '0;
  logic [FLD_W-1:0]  mon_q  = '0;
  logic [FLD_W-1:0]  day_q  = '0;
  logic [FLD_W-1:0]  hour_q = '0;
  logic [FLD_W-1:0]  min_q  = '0;
  logic [FLD_W-1:0]  sec_q  = '0;
  logic              ferr_q = 1'b0;
  sfx_kind_t         sfx_q  = SFX_NONE;

  int cum_days [12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
  int mon_len  [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  out_word_t   pending_words [$];   // words the block still owes us, oldest first
  typed_word_t typed_words [$];     // one entry per directed row, in order
  logic [7:0]  txt_q [$];           // text being sent
  idle_mode_t  idle_mode = IDLE_NONE;
  int          mismatches = 0;

  function automatic bit is_leap_year(input int y);
    return (y % 4 == 0 && y % 100 != 0) || y % 400 == 0;
  endfunction

  function automatic int days_in_month(input int m, input int y);
    return mon_len[m-1] + ((m == 2 && is_leap_year(y)) ? 1 : 0);
  endfunction

  // Random idling: tx side gaps and rx side stalls, per the current mode.
  function automatic bit idle_roll(input bit rx_side);
    if (idle_mode == IDLE_BOTH)
      return $urandom_range(99) < 36;
    if ((rx_side && idle_mode == IDLE_RX) || (!rx_side && idle_mode == IDLE_TX))
      return $urandom_range(99) < 58;
    return 1'b0;
  endfunction

  // Takes one character into the model; on the final one gives the result word
  // and clears the text.
  task automatic parse_timestamp_char(input in_word_t w, output bit done,
                                      output out_word_t res);
    logic [7:0] c;
    logic [3:0] dv;
    bit         is_dig;
    bit         ok;
    int         len;
    int         y;
    int         m;
    longint     days;
    longint     secs;
    c      = w.character;
    is_dig = c >= CH_ZERO && c <= CH_NINE;
    dv     = 4'(c - CH_ZERO);
    done   = 1'b0;
    res    = '0;
    if (pos_q >= MAX_LEN) begin
      ferr_q = 1'b1;               // too long: position sticks at 24
    end else begin
      case (pos_q)
        4, 7:       if (c != CH_DASH) ferr_q = 1'b1;
        10:         if (c != CH_T) ferr_q = 1'b1;
        13, 16:     if (c != CH_COLON) ferr_q = 1'b1;
        19: begin
          if (c == CH_Z) sfx_q = SFX_Z;
          else if (c == CH_DOT) sfx_q = SFX_DOT;
          else ferr_q = 1'b1;
        end
        20, 21, 22: if (sfx_q != SFX_DOT || !is_dig) ferr_q = 1'b1;
        23:         if (sfx_q != SFX_DOT || c != CH_Z) ferr_q = 1'b1;
        default: begin
          if (!is_dig) ferr_q = 1'b1;
          else if (pos_q <= 3)  year_q = YEAR_W'(year_q * 10 + dv);
          else if (pos_q <= 6)  mon_q  = FLD_W'(mon_q * 10 + dv);
          else if (pos_q <= 9)  day_q  = FLD_W'(day_q * 10 + dv);
          else if (pos_q <= 12) hour_q = FLD_W'(hour_q * 10 + dv);
          else if (pos_q <= 15) min_q  = FLD_W'(min_q * 10 + dv);
          else                  sec_q  = FLD_W'(sec_q * 10 + dv);
        end
      endcase
      pos_q = pos_q + 1'b1;
    end
    if (w.last) begin
      len = pos_q;
      y   = year_q;
      m   = mon_q;
      ok  = !ferr_q && (len == 19 || (len == 20 && sfx_q == SFX_Z) || len == 23 || len == 24);
      if (ok) begin
        if (m < 1 || m > 12) ok = 1'b0;
        else if (day_q < 1 || day_q > days_in_month(m, y)) ok = 1'b0;
        if (y < earliest_q || hour_q > 23 || min_q > 59 || sec_q > 59) ok = 1'b0;
      end
      if (ok) begin
        days = 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
        days = days + cum_days[m-1] + ((m > 2 && is_leap_year(y)) ? 1 : 0) + day_q - 1;
        secs = days * 86400 + hour_q * 3600 + min_q * 60 + sec_q
             - longint'(719528) * 86400;
        // years before 1970 wrap as two's complement
        res.epoch_seconds = secs[SECS_W-1:0];
      end
      res.valid_res = ok;
      done   = 1'b1;
      pos_q  = '0;
      year_q = '0;
      mon_q  = '0;
      day_q  = '0;
      hour_q = '0;
      min_q  = '0;
      sec_q  = '0;
      ferr_q = 1'b0;
      sfx_q  = SFX_NONE;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Input side: every accepted word goes through the model.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : accept_mon
    bit          done;
    out_word_t   res;
    typed_word_t tw;
    if (rst_n && in_valid && !in_stall) begin
      parse_timestamp_char(in_data, done, res);
      if (done) begin
        // Directed rows may carry a typed-in word that replaces the model's.
        if (typed_words.size() != 0) begin
          tw = typed_words.pop_front();
          if (tw.fixed) res = tw.word;
        end
        pending_words.insert(pending_words.size(), res);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output side: compare each accepted word with the oldest expectation, then
  // pick the stall for the next cycle.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    out_word_t exp_w;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_words.size() == 0) begin
        $error("result word %h with nothing expected", out_data);
        mismatches++;
      end else begin
        exp_w = pending_words.pop_front();
        if (out_data.valid_res !== exp_w.valid_res) begin
          $error("valid_res: expected %0d, got %0d", exp_w.valid_res, out_data.valid_res);
          mismatches++;
        end
        if (out_data.epoch_seconds !== exp_w.epoch_seconds) begin
          $error("epoch_seconds: expected %0d, got %0d",
                 exp_w.epoch_seconds, out_data.epoch_seconds);
          mismatches++;
        end
      end
    end
    out_stall <= idle_roll(1'b1);
  end

  // ---------------------------------------------------------------------------
  // Sender. Gaps come before a word is offered, so valid never drops while a
  // word waits out a stall; junk sits on the bus during gaps.
  // ---------------------------------------------------------------------------
  task automatic send_char(input in_word_t w);
    while (idle_roll(1'b0)) begin
      in_valid <= 1'b0;
      in_data  <= in_word_t'($urandom);
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_text();
    in_word_t w;
    for (int i = 0; i < txt_q.size(); i++) begin
      w.character = txt_q[i];
      w.last      = (i == txt_q.size() - 1);
      send_char(w);
    end
  endtask

  task automatic load_text(input string s);
    txt_q.delete();
    for (int i = 0; i < s.len(); i++) txt_q.insert(txt_q.size(), s[i]);
  endtask

  // ---------------------------------------------------------------------------
  // Directed table, checked at the reset earliest year of 1999.
  // ---------------------------------------------------------------------------
  string dir_text [DIR_ROWS] = '{
    "1970-01-01T00:00:00",            // before the reset earliest year
    "9999-12-31T23:59:59",            // top of the range
    "2000-01-01T00:00:00Z",
    "1999-01-01T00:00:00.000",
    "2024-02-29T23:59:59.999Z",       // leap day with full suffix
    "2000-02-29T00:00:00",            // century leap year
    "2100-02-29T00:00:00",            // century, not leap
    "2000-02-30T00:00:00",
    "2001-00-10T00:00:00",
    "2001-04-31T00:00:00",
    "2001-01-00T00:00:00",
    "2001-01-01T24:00:00",
    "2001-01-01T00:60:00",
    "2001-01-01T00:00:60",
    "2001-01-01T00:00",               // short
    "2001-01-01T00:00:00.1234Z",      // one past the longest shape
    "2001-01-01T00:00:00.000Z-extra", // runs well past saturation
    "2001-01-01T00:00:00Z0",          // digit after Z
    "2001-01-01T00:00:00.12",         // millis cut short
    "2001-01-01T00:00:00.",           // dot with nothing after
    "20O1-01-01 00:00:00",            // letter in a digit slot, bad separator
    "Z"                               // one-character text
  };
  row_chk_t dir_chk [DIR_ROWS] = '{
    CHK_REJECT, CHK_ACCEPT, CHK_ACCEPT, CHK_MODEL, CHK_MODEL, CHK_MODEL,
    CHK_REJECT, CHK_REJECT, CHK_REJECT, CHK_REJECT, CHK_REJECT, CHK_REJECT,
    CHK_REJECT, CHK_REJECT, CHK_REJECT, CHK_REJECT, CHK_REJECT, CHK_REJECT,
    CHK_REJECT, CHK_REJECT, CHK_REJECT, CHK_REJECT
  };
  logic [SECS_W-1:0] dir_secs [DIR_ROWS] = '{
    0, 38'd253402300799, 38'd946684800, 0, 0, 0, 0, 0, 0, 0, 0,
    0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0
  };

  // Per phase: idling mode and earliest year (index 3 gets a random year).
  idle_mode_t        phase_mode [PHASES] = '{IDLE_TX, IDLE_RX, IDLE_BOTH, IDLE_NONE,
                                             IDLE_BOTH, IDLE_RX};
  logic [YEAR_W-1:0] phase_year [PHASES] = '{14'd0, 14'd9999, 14'd1970, 14'd0,
                                             14'd2000, 14'd0};

  initial begin : stimulus
    typed_word_t tw;
    int          sent;
    int          y;
    int          mo;
    int          dy;
    int          hr;
    int          mi;
    int          se;
    int          dim;
    int          pick;
    int          n;
    int          idx;
    int          wait_n;
    logic [7:0]  b;
    string       s;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < DIR_ROWS; r++) begin
      tw.fixed                = (dir_chk[r] != CHK_MODEL);
      tw.word.valid_res       = (dir_chk[r] == CHK_ACCEPT);
      tw.word.epoch_seconds   = dir_secs[r];
      typed_words.insert(typed_words.size(), tw);
      load_text(dir_text[r]);
      send_text();
    end

    phase_year[3] = YEAR_W'($urandom_range(9999));
    for (int ph = 0; ph < PHASES; ph++) begin
      // Register write only once the block has drained and settled.
      in_valid <= 1'b0;
      do @(posedge clk); while (pending_words.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clk);
      cfg_we    <= 1'b1;
      cfg_wdata <= phase_year[ph];
      @(posedge clk);
      cfg_we     <= 1'b0;
      earliest_q  = phase_year[ph];
      idle_mode   = phase_mode[ph];

      sent = 0;
      while (sent < PHASE_ITEMS) begin
        // Now and then hold off until every result is back.
        if ($urandom_range(11) == 0) begin
          in_valid <= 1'b0;
          do @(posedge clk); while (pending_words.size() != 0);
        end
        txt_q.delete();
        pick = $urandom_range(99);
        if (pick < 10) begin
          // pure noise, any byte, any length up to past saturation
          n = $urandom_range(30, 1);
          repeat (n) begin
            b = 8'($urandom_range(255));
            txt_q.insert(txt_q.size(), b);
          end
        end else begin
          // well-formed shape, values biased around the limits
          case ($urandom_range(9))
            0, 1:    y = earliest_q;
            2:       y = (earliest_q > 0) ? earliest_q - 1 : 0;
            3, 4:    y = $urandom_range(9999);
            default: y = $urandom_range(9999, earliest_q);
          endcase
          case ($urandom_range(9))
            0, 1:    mo = 2;
            9:       mo = $urandom_range(99);
            default: mo = $urandom_range(12, 1);
          endcase
          dim = (mo >= 1 && mo <= 12) ? days_in_month(mo, y) : 31;
          case ($urandom_range(9))
            6:       dy = dim;
            7:       dy = dim + 1;
            8:       dy = 0;
            9:       dy = $urandom_range(99);
            default: dy = $urandom_range(dim, 1);
          endcase
          hr = ($urandom_range(9) == 0) ? $urandom_range(99) : $urandom_range(23);
          mi = ($urandom_range(9) == 0) ? $urandom_range(99) : $urandom_range(59);
          se = ($urandom_range(9) == 0) ? $urandom_range(99) : $urandom_range(59);
          s = $sformatf("%04d-%02d-%02dT%02d:%02d:%02d", y, mo, dy, hr, mi, se);
          case ($urandom_range(3))
            1:       s = {s, "Z"};
            2:       s = {s, $sformatf(".%03d", $urandom_range(999))};
            3:       s = {s, $sformatf(".%03dZ", $urandom_range(999))};
            default: ;
          endcase
          load_text(s);
          // a quarter of all texts are shapes that get broken
          if (pick >= 75) begin
            idx = $urandom_range(txt_q.size() - 1);
            case ($urandom_range(3))
              0: txt_q[idx] = 8'($urandom_range(255));
              1: txt_q[idx] = 8'(CH_ZERO + $urandom_range(9));
              2: begin
                n = $urandom_range(txt_q.size() - 1, 1);
                txt_q = txt_q[0:n-1];
              end
              default: begin
                n = $urandom_range(10, 1);
                repeat (n) begin
                  b = $urandom_range(1) ? 8'(CH_ZERO + $urandom_range(9))
                                        : 8'($urandom_range(255));
                  txt_q.insert(txt_q.size(), b);
                end
              end
            endcase
          end
        end
        sent += txt_q.size();
        send_text();
      end
    end

    in_valid <= 1'b0;
    for (wait_n = 0; wait_n < DRAIN_LIMIT && pending_words.size() != 0; wait_n++)
      @(posedge clk);
    if (pending_words.size() != 0) begin
      $error("%0d result words never arrived", pending_words.size());
      mismatches++;
    end
    // Room for any stray word after the last expected one.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
